// ===== src/gna_pkg.sv =====
// Shared constants, types and helpers of the Gaussian noise adder.
package gna_pkg;

    localparam logic [31:0] LN2_Q32       = 32'd2977044472;
    localparam logic [31:0] PI_HALF_Q30   = 32'd1686629713;
    localparam logic [30:0] ONE_Q30       = 31'd1073741824;
    localparam logic [15:0] INV_SQRT2_Q16 = 16'd46341;

    // Register indexes of the configuration port
    localparam logic CFG_NOISE_STD    = 1'b0;
    localparam logic CFG_COMPLEX_MODE = 1'b1;

    // Pipeline depths
    localparam int SQ_STEPS   = 16;
    localparam int SQRT_STEPS = 19;
    localparam int RAD_LAT    = 2 + SQ_STEPS + 1 + SQRT_STEPS;
    localparam int TRIG_LAT   = 10;
    localparam int COMB_LAT   = 3;
    localparam int TOTAL_LAT  = RAD_LAT + COMB_LAT;

    // Exact reciprocal multipliers for floor(v / c), v < 2^31:
    // m = ceil(2^(31+l) / c), l = ceil(log2 c)
    localparam logic [32:0] DIV42_M = 33'(((64'd1 << 37) + 64'd41) / 64'd42);
    localparam logic [32:0] DIV56_M = 33'(((64'd1 << 37) + 64'd55) / 64'd56);
    localparam logic [32:0] DIV20_M = 33'(((64'd1 << 36) + 64'd19) / 64'd20);
    localparam logic [32:0] DIV30_M = 33'(((64'd1 << 36) + 64'd29) / 64'd30);
    localparam logic [32:0] DIV6_M  = 33'(((64'd1 << 34) + 64'd5) / 64'd6);
    localparam logic [32:0] DIV12_M = 33'(((64'd1 << 35) + 64'd11) / 64'd12);
    localparam logic [5:0]  DIV42_SH = 6'd37;
    localparam logic [5:0]  DIV56_SH = 6'd37;
    localparam logic [5:0]  DIV20_SH = 6'd36;
    localparam logic [5:0]  DIV30_SH = 6'd36;
    localparam logic [5:0]  DIV6_SH  = 6'd34;
    localparam logic [5:0]  DIV12_SH = 6'd35;

    typedef struct packed {
        logic [30:0] smag;
        logic        sneg;
        logic [30:0] cmag;
        logic        cneg;
    } gna_trig_t;

    // Divide by a small constant through its reciprocal multiplier
    function automatic logic [30:0] div_recip(input logic [30:0] v,
                                              input logic [32:0] mul,
                                              input logic [5:0] sh);
        logic [63:0] prod;
        prod = 64'(v) * 64'(mul);
        return 31'(prod >> sh);
    endfunction

endpackage

// ===== src/gna_radius.sv =====
// Radius pipeline: r = sqrt(-2 ln u1) through log2 by squaring and a bitwise square root.
module gna_radius (
    input  logic        aclk,
    input  logic        adv,
    input  logic [31:0] uniform_a,
    output logic [18:0] radius
);
    import gna_pkg::*;

    // normalize, first step: byte position of the leading one
    logic [1:0]  nb_reg;
    logic [31:0] nw_reg;
    logic [31:0] a1;
    logic [1:0]  nb_next;
    logic [31:0] nw_next;

    always_comb begin
        a1 = (uniform_a == 32'd0) ? 32'd1 : uniform_a;
        if (|a1[31:24]) begin
            nb_next = 2'd3;
            nw_next = a1;
        end else if (|a1[23:16]) begin
            nb_next = 2'd2;
            nw_next = a1 << 8;
        end else if (|a1[15:8]) begin
            nb_next = 2'd1;
            nw_next = a1 << 16;
        end else begin
            nb_next = 2'd0;
            nw_next = a1 << 24;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            nb_reg <= nb_next;
            nw_reg <= nw_next;
        end
    end

    // normalize, second step: bit position inside the top byte
    logic [2:0]  pos;
    logic [31:0] sq_m_reg [0:SQ_STEPS];
    logic [15:0] sq_f_reg [0:SQ_STEPS];
    logic [4:0]  sq_p_reg [0:SQ_STEPS];

    always_comb begin
        pos = 3'd0;
        for (int k = 0; k < 8; k++) begin
            if (nw_reg[24 + k]) pos = 3'(k);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_p_reg[0] <= {nb_reg, pos};
            sq_m_reg[0] <= nw_reg << (3'd7 - pos);
            sq_f_reg[0] <= 16'd0;
        end
    end

    // one fraction bit of log2 per stage
    for (genvar i = 1; i <= SQ_STEPS; i++) begin : g_sq
        logic [63:0] prod;
        logic [32:0] sq;
        assign prod = 64'(sq_m_reg[i-1]) * 64'(sq_m_reg[i-1]);
        assign sq   = prod[63:31];
        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_p_reg[i] <= sq_p_reg[i-1];
                sq_f_reg[i] <= {sq_f_reg[i-1][14:0], sq[32]};
                sq_m_reg[i] <= sq[32] ? sq[32:1] : sq[31:0];
            end
        end
    end

    // scale by 2 ln2
    logic [21:0] lval;
    logic [53:0] lprod;
    logic [37:0] qv_reg [0:SQRT_STEPS];
    logic [37:0] qr_reg [0:SQRT_STEPS];

    assign lval  = 22'd2097152 - 22'({sq_p_reg[SQ_STEPS], sq_f_reg[SQ_STEPS]});
    assign lprod = 54'(lval) * 54'(LN2_Q32);

    always_ff @(posedge aclk) begin
        if (adv) begin
            qv_reg[0] <= lprod[52:15];
            qr_reg[0] <= 38'd0;
        end
    end

    // one result bit of the square root per stage
    for (genvar j = 1; j <= SQRT_STEPS; j++) begin : g_sqrt
        localparam logic [38:0] BIT = 39'd1 << (2 * (SQRT_STEPS - j));
        logic [38:0] trial;
        assign trial = {1'b0, qr_reg[j-1]} + BIT;
        always_ff @(posedge aclk) begin
            if (adv) begin
                if ({1'b0, qv_reg[j-1]} >= trial) begin
                    qv_reg[j] <= 38'({1'b0, qv_reg[j-1]} - trial);
                    qr_reg[j] <= 38'({2'b0, qr_reg[j-1][37:1]} + BIT);
                end else begin
                    qv_reg[j] <= qv_reg[j-1];
                    qr_reg[j] <= {1'b0, qr_reg[j-1][37:1]};
                end
            end
        end
    end

    assign radius = qr_reg[SQRT_STEPS][18:0];

endmodule

// ===== src/gna_trig.sv =====
// Sine and cosine pipeline for the angle 2*pi*u2 by folded Taylor polynomials.
module gna_trig (
    input  logic                 aclk,
    input  logic                 adv,
    input  logic [31:0]          uniform_b,
    output gna_pkg::gna_trig_t   trig
);
    import gna_pkg::*;

    logic [1:0]  q_reg [0:8];
    logic        sw_reg [0:8];
    logic [29:0] x0_reg;
    logic [29:0] x_reg [1:7];
    logic [29:0] x2_reg [2:7];
    logic [30:0] ts_reg, tc_reg, ps_reg, pc_reg;
    logic [30:0] ts3_reg, tc3_reg, ts5_reg, tc5_reg, ts7_reg, tc7_reg;
    logic [30:0] sv_reg, pc8_reg;
    gna_trig_t   trig_reg;
    gna_trig_t   trig_next;

    logic [29:0] f;
    logic        swap;
    logic [61:0] xprod, x2prod;
    logic [60:0] ps4, pc4, ps6, pc6, sv8, pc8;
    logic [30:0] cv, s0, c0;

    assign f     = uniform_b[29:0];
    assign swap  = f > 30'h20000000;
    assign xprod = 62'(x0_reg) * 62'(PI_HALF_Q30);
    assign x2prod = 62'(x_reg[1]) * 62'(x_reg[1]);
    assign ps4   = 61'(x2_reg[3]) * 61'(ts3_reg);
    assign pc4   = 61'(x2_reg[3]) * 61'(tc3_reg);
    assign ps6   = 61'(x2_reg[5]) * 61'(ts5_reg);
    assign pc6   = 61'(x2_reg[5]) * 61'(tc5_reg);
    assign sv8   = 61'(x_reg[7]) * 61'(ts7_reg);
    assign pc8   = 61'(x2_reg[7]) * 61'(tc7_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            // fold to [0, pi/4]
            q_reg[0]  <= uniform_b[31:30];
            sw_reg[0] <= swap;
            x0_reg    <= swap ? 30'(31'h40000000 - 31'(f)) : f;
            for (int k = 1; k <= 8; k++) begin
                q_reg[k]  <= q_reg[k-1];
                sw_reg[k] <= sw_reg[k-1];
            end
            x_reg[1] <= xprod[59:30];
            for (int k = 2; k <= 7; k++) x_reg[k] <= x_reg[k-1];
            x2_reg[2] <= x2prod[59:30];
            for (int k = 3; k <= 7; k++) x2_reg[k] <= x2_reg[k-1];
            ts3_reg <= ONE_Q30 - div_recip(31'(x2_reg[2]), DIV42_M, DIV42_SH);
            tc3_reg <= ONE_Q30 - div_recip(31'(x2_reg[2]), DIV56_M, DIV56_SH);
            ps_reg  <= ps4[60:30];
            pc_reg  <= pc4[60:30];
            ts5_reg <= ONE_Q30 - div_recip(ps_reg, DIV20_M, DIV20_SH);
            tc5_reg <= ONE_Q30 - div_recip(pc_reg, DIV30_M, DIV30_SH);
            ts_reg  <= ps6[60:30];
            tc_reg  <= pc6[60:30];
            ts7_reg <= ONE_Q30 - div_recip(ts_reg, DIV6_M, DIV6_SH);
            tc7_reg <= ONE_Q30 - div_recip(tc_reg, DIV12_M, DIV12_SH);
            sv_reg  <= sv8[60:30];
            pc8_reg <= pc8[60:30];
            trig_reg <= trig_next;
        end
    end

    // unfold: swap back and apply the quadrant
    always_comb begin
        cv = ONE_Q30 - (pc8_reg >> 1);
        s0 = sw_reg[8] ? cv : sv_reg;
        c0 = sw_reg[8] ? sv_reg : cv;
        case (q_reg[8])
            2'd0:    trig_next = '{smag: s0, sneg: 1'b0, cmag: c0, cneg: 1'b0};
            2'd1:    trig_next = '{smag: c0, sneg: 1'b0, cmag: s0, cneg: 1'b1};
            2'd2:    trig_next = '{smag: s0, sneg: 1'b1, cmag: c0, cneg: 1'b1};
            default: trig_next = '{smag: c0, sneg: 1'b1, cmag: s0, cneg: 1'b0};
        endcase
    end

    assign trig = trig_reg;

endmodule

// ===== src/gna_combine.sv =====
// Noise scaling, rounding, addition and saturation; its last stage is the output register.
module gna_combine (
    input  logic               aclk,
    input  logic               adv,
    input  logic [18:0]        radius,
    input  gna_pkg::gna_trig_t trig,
    input  logic signed [15:0] sample_re,
    input  logic signed [15:0] sample_im,
    input  logic [15:0]        noise_std,
    input  logic               complex_mode,
    output logic signed [15:0] noisy_re,
    output logic signed [15:0] noisy_im,
    output logic               clipped
);
    import gna_pkg::*;

    logic [30:0] tre;
    logic        nre_neg;
    logic [49:0] mre_prod, mim_prod;
    logic [31:0] gain;

    assign tre      = complex_mode ? trig.cmag : trig.smag;
    assign nre_neg  = complex_mode ? trig.cneg : trig.sneg;
    assign mre_prod = 50'(radius) * 50'(tre);
    assign mim_prod = 50'(radius) * 50'(trig.smag);
    assign gain     = complex_mode ? 32'(noise_std) * 32'(INV_SQRT2_Q16)
                                   : {noise_std, 16'd0};

    logic [25:0] mre_reg, mim_reg;
    logic [31:0] gain_reg;
    logic        nre_neg_reg [1:2];
    logic        nim_neg_reg [1:2];
    logic        cplx_reg [1:2];
    logic signed [15:0] re_reg [1:2];
    logic signed [15:0] im_reg [1:2];
    logic [21:0] nre_reg, nim_reg;
    logic [58:0] sre_prod, sim_prod;

    assign sre_prod = 59'(mre_reg) * 59'(gain_reg) + (59'd1 << 36);
    assign sim_prod = 59'(mim_reg) * 59'(gain_reg) + (59'd1 << 36);

    always_ff @(posedge aclk) begin
        if (adv) begin
            mre_reg        <= mre_prod[49:24];
            mim_reg        <= mim_prod[49:24];
            gain_reg       <= gain;
            nre_neg_reg[1] <= nre_neg;
            nim_neg_reg[1] <= trig.sneg;
            cplx_reg[1]    <= complex_mode;
            re_reg[1]      <= sample_re;
            im_reg[1]      <= sample_im;
            nre_reg        <= sre_prod[58:37];
            nim_reg        <= sim_prod[58:37];
            nre_neg_reg[2] <= nre_neg_reg[1];
            nim_neg_reg[2] <= nim_neg_reg[1];
            cplx_reg[2]    <= cplx_reg[1];
            re_reg[2]      <= re_reg[1];
            im_reg[2]      <= im_reg[1];
        end
    end

    logic signed [23:0] sum_re, sum_im;
    logic signed [15:0] out_re_next, out_im_next;
    logic               clip_re, clip_im;

    always_comb begin
        sum_re = nre_neg_reg[2] ? 24'(re_reg[2]) - $signed({2'b0, nre_reg})
                                : 24'(re_reg[2]) + $signed({2'b0, nre_reg});
        sum_im = nim_neg_reg[2] ? 24'(im_reg[2]) - $signed({2'b0, nim_reg})
                                : 24'(im_reg[2]) + $signed({2'b0, nim_reg});
        clip_re = 1'b0;
        clip_im = 1'b0;
        if (sum_re > 24'sd32767) begin
            out_re_next = 16'sd32767;
            clip_re = 1'b1;
        end else if (sum_re < -24'sd32768) begin
            out_re_next = -16'sd32768;
            clip_re = 1'b1;
        end else begin
            out_re_next = sum_re[15:0];
        end
        // real mode: pass the imaginary part through
        if (!cplx_reg[2]) begin
            out_im_next = im_reg[2];
        end else if (sum_im > 24'sd32767) begin
            out_im_next = 16'sd32767;
            clip_im = 1'b1;
        end else if (sum_im < -24'sd32768) begin
            out_im_next = -16'sd32768;
            clip_im = 1'b1;
        end else begin
            out_im_next = sum_im[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            noisy_re <= out_re_next;
            noisy_im <= out_im_next;
            clipped  <= clip_re | clip_im;
        end
    end

endmodule

// ===== src/gaussian_noise_adder_unit.sv =====
// Top level of the Box-Muller Gaussian noise adder.
//
// Input channel (s_*): one complex Q1.15 sample and two 32-bit uniform words
// per transaction. Output channel (m_*): the noisy sample and a clip flag.
// Both are valid/ready; a transaction moves when valid and ready are high.
// The configuration port writes noise_std (index 0) or complex_mode
// (index 1) on any edge with cfg_we high; write it only while idle.
//
// From input transaction to result the path runs through 38 stages of the
// radius pipeline (2 normalize, 16 log2 squaring steps, 1 scale, 19 square
// root steps) and 3 stages of noise scaling and saturation. The sine and
// cosine pipeline runs in parallel in 10 stages. Throughput is one
// transaction per cycle while the receiver does not stall.
//
// Reset clears the valid bits and the configuration. When the receiver
// stalls with a result waiting, the whole pipeline holds and s_ready drops;
// nothing is lost or repeated.
module gaussian_noise_adder_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_sample_re,
    input  logic signed [15:0] s_sample_im,
    input  logic [31:0]        s_uniform_a,
    input  logic [31:0]        s_uniform_b,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_noisy_re,
    output logic signed [15:0] m_noisy_im,
    output logic               m_clipped,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_wdata
);
    import gna_pkg::*;

    localparam int DLY_TRIG = RAD_LAT - TRIG_LAT;

    logic [15:0]          noise_std_reg;
    logic                 complex_mode_reg;
    logic [TOTAL_LAT-1:0] vld_reg;
    logic                 adv;

    // advance unless a finished result is stuck at the output
    assign adv     = !vld_reg[TOTAL_LAT-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[TOTAL_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            noise_std_reg    <= 16'd0;
            complex_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_NOISE_STD:    noise_std_reg    <= cfg_wdata;
                CFG_COMPLEX_MODE: complex_mode_reg <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[TOTAL_LAT-2:0], s_valid};
        end
    end

    logic [18:0] radius;
    gna_trig_t   trig;

    gna_radius u_radius (
        .aclk      (aclk),
        .adv       (adv),
        .uniform_a (s_uniform_a),
        .radius    (radius)
    );

    gna_trig u_trig (
        .aclk      (aclk),
        .adv       (adv),
        .uniform_b (s_uniform_b),
        .trig      (trig)
    );

    // align samples and trig values with the radius
    logic signed [15:0] re_dly_reg [0:RAD_LAT-1];
    logic signed [15:0] im_dly_reg [0:RAD_LAT-1];
    gna_trig_t          trig_dly_reg [0:DLY_TRIG-1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            re_dly_reg[0] <= s_sample_re;
            im_dly_reg[0] <= s_sample_im;
            for (int k = 1; k < RAD_LAT; k++) begin
                re_dly_reg[k] <= re_dly_reg[k-1];
                im_dly_reg[k] <= im_dly_reg[k-1];
            end
            trig_dly_reg[0] <= trig;
            for (int k = 1; k < DLY_TRIG; k++) trig_dly_reg[k] <= trig_dly_reg[k-1];
        end
    end

    gna_combine u_combine (
        .aclk         (aclk),
        .adv          (adv),
        .radius       (radius),
        .trig         (trig_dly_reg[DLY_TRIG-1]),
        .sample_re    (re_dly_reg[RAD_LAT-1]),
        .sample_im    (im_dly_reg[RAD_LAT-1]),
        .noise_std    (noise_std_reg),
        .complex_mode (complex_mode_reg),
        .noisy_re     (m_noisy_re),
        .noisy_im     (m_noisy_im),
        .clipped      (m_clipped)
    );

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(vld_reg))
        else $error("pipeline moved during output stall");

    a_clip_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_clipped) |-> (m_noisy_re == 16'sd32767 || m_noisy_re == -16'sd32768
            || m_noisy_im == 16'sd32767 || m_noisy_im == -16'sd32768))
        else $error("clip flag without a saturated part");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule
